@@ hdl/jtdd_pkg.sv @@
package jtdd_pkg;

	localparam int unsigned RootW       = 16;
	localparam int unsigned RemW        = 2 * RootW;
	localparam int unsigned TrialW      = RemW + 2;
	localparam int unsigned WheelOffset = 100;
	localparam int unsigned DutyDivisor = 78;
	localparam int unsigned DutyMax     = 255;
	localparam int unsigned DutyW       = 8;
	localparam int unsigned RecipShift  = 21;
	localparam int unsigned RecipMul    = (2 ** RecipShift + DutyDivisor - 1) / DutyDivisor;
	localparam int unsigned RecipW      = 15;
	localparam int unsigned ScaleW      = 2 * RecipW;
	localparam int unsigned SatRoot     = DutyDivisor * (DutyMax + 1);

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
	} lane_t;

	typedef struct packed {
		logic  fwd;
		lane_t r;
		lane_t l;
	} sq_t;

endpackage

@@ hdl/jtdd_front.sv @@
module jtdd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] joy_x,
	input  logic signed [7:0] joy_y,
	output logic              next_valid,
	output jtdd_pkg::sq_t     next_data,
	input  logic              next_ready
);
	import jtdd_pkg::*;

	logic signed [8:0]  dxr, dxl;
	logic signed [17:0] pr, pl;
	logic signed [15:0] px, py;
	logic               ready_s1, ready_s2;
	logic               valid_s1, valid_s2;
	logic               fwd_s1;
	logic [14:0]        sqx_s1, sqy_s1;
	logic [15:0]        sqr_s1, sql_s1;
	logic [15:0]        r2;
	logic [16:0]        d2r, d2l;
	logic [32:0]        mr, ml;
	sq_t                data_s2;

	// squared distances
	always_comb begin
		dxr = 9'(joy_x) - 9'(WheelOffset);
		dxl = 9'(joy_x) + 9'(WheelOffset);
		pr  = dxr * dxr;
		pl  = dxl * dxl;
		px  = joy_x * joy_x;
		py  = joy_y * joy_y;
	end

	assign ready_s2 = !valid_s2 || next_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			fwd_s1 <= !joy_y[7] && (|joy_y);
			sqx_s1 <= px[14:0];
			sqy_s1 <= py[14:0];
			sqr_s1 <= pr[15:0];
			sql_s1 <= pl[15:0];
		end
	end

	// products of squared distances
	always_comb begin
		r2  = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		d2r = {1'b0, sqr_s1} + {2'b0, sqy_s1};
		d2l = {1'b0, sql_s1} + {2'b0, sqy_s1};
		mr  = 33'(d2r) * 33'(r2);
		ml  = 33'(d2l) * 33'(r2);
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2.fwd    <= fwd_s1;
			data_s2.r.rem  <= mr[RemW-1:0];
			data_s2.r.root <= '0;
			data_s2.l.rem  <= ml[RemW-1:0];
			data_s2.l.root <= '0;
		end
	end

	assign next_valid = valid_s2;
	assign next_data  = data_s2;

endmodule

@@ hdl/jtdd_sqrt_cell.sv @@
module jtdd_sqrt_cell #(
	parameter int unsigned BIT = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          prev_valid,
	input  jtdd_pkg::sq_t prev_data,
	output logic          prev_ready,
	output logic          next_valid,
	output jtdd_pkg::sq_t next_data,
	input  logic          next_ready
);
	import jtdd_pkg::*;

	logic valid_q;
	sq_t  data_q;
	sq_t  step_d;

	// one root bit: take it if (root + 2^BIT)^2 still fits under the radicand
	function automatic lane_t root_step(lane_t a);
		logic [TrialW-1:0] trial;
		lane_t             o;
		trial = (TrialW'(a.root) << (BIT + 1)) + (TrialW'(1) << (2 * BIT));
		o     = a;
		if (TrialW'(a.rem) >= trial) begin
			o.rem  = a.rem - trial[RemW-1:0];
			o.root = a.root | (RootW'(1) << BIT);
		end
		return o;
	endfunction

	always_comb begin
		step_d.fwd = prev_data.fwd;
		step_d.r   = root_step(prev_data.r);
		step_d.l   = root_step(prev_data.l);
	end

	assign prev_ready = !valid_q || next_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prev_ready) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) data_q <= step_d;
	end

	assign next_valid = valid_q;
	assign next_data  = data_q;

endmodule

@@ hdl/jtdd_back.sv @@
module jtdd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          prev_valid,
	input  jtdd_pkg::sq_t prev_data,
	output logic          prev_ready,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    duty_right,
	output logic [7:0]    duty_left,
	output logic          forward
);
	import jtdd_pkg::*;

	logic              ready_s1, ready_o;
	logic              valid_s1, valid_q;
	logic              fwd_s1, sat_r_s1, sat_l_s1;
	logic [ScaleW-1:0] scl_r_s1, scl_l_s1;
	logic              fwd_q;
	logic [DutyW-1:0]  duty_r_q, duty_l_q;

	assign ready_o    = !valid_q || !out_stall;
	assign ready_s1   = !valid_s1 || ready_o;
	assign prev_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= prev_valid;
			if (ready_o)  valid_q  <= valid_s1;
		end
	end

	// divide by reciprocal multiply, exact for roots below the saturation point
	always_ff @(posedge clk) begin
		if (ready_s1 && prev_valid) begin
			fwd_s1   <= prev_data.fwd;
			sat_r_s1 <= prev_data.r.root >= RootW'(SatRoot);
			sat_l_s1 <= prev_data.l.root >= RootW'(SatRoot);
			scl_r_s1 <= ScaleW'(prev_data.r.root[RecipW-1:0]) * ScaleW'(RecipMul);
			scl_l_s1 <= ScaleW'(prev_data.l.root[RecipW-1:0]) * ScaleW'(RecipMul);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_s1) begin
			fwd_q    <= fwd_s1;
			duty_r_q <= sat_r_s1 ? DutyW'(DutyMax) : scl_r_s1[RecipShift+DutyW-1:RecipShift];
			duty_l_q <= sat_l_s1 ? DutyW'(DutyMax) : scl_l_s1[RecipShift+DutyW-1:RecipShift];
		end
	end

	assign out_valid  = valid_q;
	assign duty_right = duty_r_q;
	assign duty_left  = duty_l_q;
	assign forward    = fwd_q;

endmodule

@@ hdl/joystick_to_differential_drive_core.sv @@
// Joystick to differential drive: each (joy_x, joy_y) item yields one item with two 8-bit
// duty values, floor(isqrt(d2 * r2) / 78) saturated at 255, and a forward bit (joy_y > 0).
// An item is accepted every cycle when the output is not stalled. The path is registered
// in order: squares and products, sixteen root cells that each settle one bit of the
// 16-bit square root for both wheels, then the reciprocal-multiply divide, saturation and
// the output register. A stall on the output fills empty stages first.
module joystick_to_differential_drive_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic signed [7:0] joy_x,
	input  logic signed [7:0] joy_y,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        duty_right,
	output logic [7:0]        duty_left,
	output logic              forward
);
	import jtdd_pkg::*;

	logic chain_v [RootW+1];
	logic chain_r [RootW+1];
	sq_t  chain_d [RootW+1];

	jtdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.joy_x      (joy_x),
		.joy_y      (joy_y),
		.next_valid (chain_v[0]),
		.next_data  (chain_d[0]),
		.next_ready (chain_r[0])
	);

	for (genvar i = 0; i < RootW; i++) begin : g_cell
		jtdd_sqrt_cell #(
			.BIT (RootW - 1 - i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (chain_v[i]),
			.prev_data  (chain_d[i]),
			.prev_ready (chain_r[i]),
			.next_valid (chain_v[i+1]),
			.next_data  (chain_d[i+1]),
			.next_ready (chain_r[i+1])
		);
	end

	jtdd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (chain_v[RootW]),
		.prev_data  (chain_d[RootW]),
		.prev_ready (chain_r[RootW]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.duty_right (duty_right),
		.duty_left  (duty_left),
		.forward    (forward)
	);

`ifndef SYNTHESIS
	// finished root leaves a remainder no larger than twice the root
	a_rem_right: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[RootW] |-> chain_d[RootW].r.rem <= RemW'({chain_d[RootW].r.root, 1'b0}))
		else $error("right root remainder out of bound");
	a_rem_left: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[RootW] |-> chain_d[RootW].l.rem <= RemW'({chain_d[RootW].l.root, 1'b0}))
		else $error("left root remainder out of bound");
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");
	a_hold_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(chain_v[RootW] && !chain_r[RootW]) |=> chain_v[RootW])
		else $error("item lost at end of root chain");
`endif

endmodule

@@ tb/sv/jtdd_drive_checker.sv @@
`timescale 1ns / 100ps

module jtdd_drive_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic signed [7:0] joy_x,
	input  logic signed [7:0] joy_y,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        duty_right,
	input  logic [7:0]        duty_left,
	input  logic              forward,
	output int                n_mismatch,
	output int                n_waiting,
	output int                n_checked
);

	import jtdd_pkg::*;

	typedef struct packed {
		logic [7:0] right;
		logic [7:0] left;
		logic       fwd;
	} drive_t;

	drive_t drive_q[$];
	int     bad_cnt;
	int     chk_cnt;

	// largest root whose square does not exceed the product, settled bit by bit
	function automatic longint unsigned root_floor(input longint unsigned prod);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		for (int k = 16; k >= 0; k--) begin
			trial = acc | (64'd1 << k);
			if (trial * trial <= prod)
				acc = trial;
		end
		return acc;
	endfunction

	function automatic logic [7:0] wheel_duty(input int dx, input int y,
		input longint unsigned r2);
		longint unsigned d2;
		longint unsigned q;
		d2 = longint'(dx * dx) + longint'(y * y);
		q  = root_floor(d2 * r2) / DutyDivisor;
		return (q > DutyMax) ? 8'(DutyMax) : q[7:0];
	endfunction

	function automatic drive_t drive_for(input logic signed [7:0] px,
		input logic signed [7:0] py);
		drive_t          d;
		int              x;
		int              y;
		longint unsigned r2;
		x       = px;
		y       = py;
		r2      = longint'(x * x) + longint'(y * y);
		d.right = wheel_duty(x - int'(WheelOffset), y, r2);
		d.left  = wheel_duty(x + int'(WheelOffset), y, r2);
		d.fwd   = (y > 0);
		return d;
	endfunction

	initial begin
		bad_cnt    = 0;
		chk_cnt    = 0;
		n_mismatch = 0;
		n_waiting  = 0;
		n_checked  = 0;
	end

	always @(posedge clk) begin
		drive_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				drive_q.push_back(drive_for(joy_x, joy_y));
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected item right=%0d left=%0d forward=%0b",
						$time, duty_right, duty_left, forward);
					bad_cnt++;
				end else begin
					want = drive_q.pop_front();
					chk_cnt++;
					if (duty_right !== want.right) begin
						$display("%0t: duty_right expected %0d actual %0d",
							$time, want.right, duty_right);
						bad_cnt++;
					end
					if (duty_left !== want.left) begin
						$display("%0t: duty_left expected %0d actual %0d",
							$time, want.left, duty_left);
						bad_cnt++;
					end
					if (forward !== want.fwd) begin
						$display("%0t: forward expected %0b actual %0b",
							$time, want.fwd, forward);
						bad_cnt++;
					end
				end
			end
		end
		n_mismatch <= bad_cnt;
		n_checked  <= chk_cnt;
		n_waiting  <= drive_q.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic signed [7:0] joy_x;
	logic signed [7:0] joy_y;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        duty_right;
	logic [7:0]        duty_left;
	logic              forward;

	int n_mismatch;
	int n_waiting;
	int n_checked;
	int n_sent;
	int send_gap_pct;
	int ret_stall_pct;
	int hold_left;

	joystick_to_differential_drive_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.joy_x      (joy_x),
		.joy_y      (joy_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.duty_right (duty_right),
		.duty_left  (duty_left),
		.forward    (forward)
	);

	jtdd_drive_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.joy_x      (joy_x),
		.joy_y      (joy_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.duty_right (duty_right),
		.duty_left  (duty_left),
		.forward    (forward),
		.n_mismatch (n_mismatch),
		.n_waiting  (n_waiting),
		.n_checked  (n_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("%0t: timeout with %0d items outstanding", $time, n_waiting);
		$display("** joystick_to_differential_drive_core: FAILED **");
		$finish;
	end

	// output side: random stall plus a long hold while hold_left counts down
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < ret_stall_pct);
			end
		end
	end

	task automatic send_point(input logic signed [7:0] x, input logic signed [7:0] y);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		joy_x    <= x;
		joy_y    <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// mostly the nominal square, sometimes anywhere in the 8-bit range
	function automatic logic signed [7:0] pick_coord();
		int v;
		if ($urandom_range(99) < 85)
			v = int'($urandom_range(200)) - 100;
		else
			v = int'($urandom_range(255)) - 128;
		return v[7:0];
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_point(pick_coord(), pick_coord());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_waiting != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [7:0] corner_x[24];
		logic signed [7:0] corner_y[24];
		corner_x = '{0, 100, -100, 0, 0, 100, -100, 100, -100, 127, -128, -128,
			127, 0, 0, 1, -1, 50, -128, 127, 0, 0, 1, -1};
		corner_y = '{0, 0, 0, 100, -100, 100, -100, -100, 100, 127, -128, 127,
			-128, 1, -1, 0, 0, 50, 0, 0, -128, 127, 1, -1};
		arst_n        = 1'b0;
		in_valid      <= 1'b0;
		joy_x         <= '0;
		joy_y         <= '0;
		n_sent        = 0;
		hold_left     = 0;
		send_gap_pct  = 19;
		ret_stall_pct = 76;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners, axes, origin and out-of-range points
		for (int i = 0; i < 24; i++)
			send_point(corner_x[i], corner_y[i]);
		send_random(300);

		// long output hold while items keep coming, then a full drain
		wait_drained();
		send_gap_pct  = 0;
		ret_stall_pct = 0;
		hold_left     = 150;
		send_random(60);
		wait_drained();

		send_gap_pct  = 76;
		ret_stall_pct = 19;
		send_random(340);

		send_gap_pct  = 0;
		ret_stall_pct = 0;
		send_random(326);

		wait_drained();
		repeat (40) @(posedge clk);

		$display("sent %0d joystick points, checked %0d drive items", n_sent, n_checked);
		$display("phases: slow output, long output hold with drain, slow input, full rate");
		if (n_mismatch == 0 && n_waiting == 0) begin
			$display("** joystick_to_differential_drive_core: PASSED **");
		end else begin
			if (n_waiting != 0)
				$display("%0t: %0d expected items never arrived", $time, n_waiting);
			$display("** joystick_to_differential_drive_core: FAILED **");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/jtdd_pkg.sv
hdl/jtdd_front.sv
hdl/jtdd_sqrt_cell.sv
hdl/jtdd_back.sv
hdl/joystick_to_differential_drive_core.sv
tb/sv/jtdd_drive_checker.sv
tb/sv/tb_top.sv
